@@ rtl/core/rcpwm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// RC PWM capture package
// Shared widths, reset values, register indexes and the command and status
// structures that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package rcpwm_pkg;

	// Field widths fixed by the interface.
	localparam int unsigned CH_W    = 3;
	localparam int unsigned PULSE_W = 12;
	localparam int unsigned TIME_W  = 32;
	localparam int unsigned IDX_REG_W = 2;

	// Default channel count.
	localparam int unsigned NUM_CHANNELS_DEF = 8;

	// Reset values.
	localparam logic [PULSE_W-1:0] MIN_PULSE_RST   = 12'd800;
	localparam logic [PULSE_W-1:0] MAX_PULSE_RST   = 12'd2200;
	localparam logic [TIME_W-1:0]  LINK_TIMEOUT_RST = 32'd100000;
	localparam logic [PULSE_W-1:0] WIDTH_RST       = 12'd1500;
	localparam logic [TIME_W-1:0]  NEVER_SEEN_AGE  = 32'hFFFF_FFFF;

	// Configuration register indexes.
	localparam logic [IDX_REG_W-1:0] REG_MIN_PULSE    = 2'd0;
	localparam logic [IDX_REG_W-1:0] REG_MAX_PULSE    = 2'd1;
	localparam logic [IDX_REG_W-1:0] REG_LINK_TIMEOUT = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;     // capture the input transaction
		logic edge_op;  // process a pin edge
		logic scan;     // fold one channel age into the poll summary
		logic cap;      // limit the worst age to timeout plus one
		logic lf;       // form the last-frame time
		logic advance;  // step to the next result channel
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic kind;      // latched item kind, 1 for a poll
		logic cnt_last;  // channel counter on the final channel
	} sts_t;

endpackage
`default_nettype wire

@@ rtl/core/rcpwm_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// RC PWM capture datapath
// Holds the configuration, the per-channel capture state and the poll
// summary, and performs the arithmetic that the controller sequences.
// ----------------------------------------------------------------------------
module rcpwm_dp #(
	parameter int unsigned NUM_CHANNELS = rcpwm_pkg::NUM_CHANNELS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [rcpwm_pkg::IDX_REG_W-1:0]     cfg_index,
	input  wire logic [rcpwm_pkg::TIME_W-1:0]        cfg_data,
	input  wire logic                                kind,
	input  wire logic [rcpwm_pkg::CH_W-1:0]          channel,
	input  wire logic                                edge_level,
	input  wire logic [rcpwm_pkg::TIME_W-1:0]        now_us,
	input  wire rcpwm_pkg::cmd_t                     cmd,
	output rcpwm_pkg::sts_t                          sts,
	output logic [rcpwm_pkg::CH_W-1:0]               out_channel,
	output logic [rcpwm_pkg::PULSE_W-1:0]            chan_width,
	output logic                                     link_valid,
	output logic [rcpwm_pkg::TIME_W-1:0]             frame_time_us,
	output logic                                     last
);

	localparam int unsigned IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int unsigned TW    = rcpwm_pkg::TIME_W;
	localparam int unsigned PW    = rcpwm_pkg::PULSE_W;

	// Configuration registers.
	logic [PW-1:0] min_pulse_q;
	logic [PW-1:0] max_pulse_q;
	logic [TW-1:0] timeout_q;

	// Latched input transaction.
	logic                      kind_q;
	logic [rcpwm_pkg::CH_W-1:0] ch_q;
	logic                      level_q;
	logic [TW-1:0]             now_q;

	// Per-channel capture state.
	logic [TW-1:0] start_q [NUM_CHANNELS];
	logic [PW-1:0] width_q [NUM_CHANNELS];
	logic [TW-1:0] seen_t_q [NUM_CHANNELS];
	logic          seen_q  [NUM_CHANNELS];

	// Poll summary.
	logic [IDX_W-1:0] cnt_q;
	logic [TW-1:0]    worst_q;
	logic             fresh_q;
	logic [TW-1:0]    lf_q;

	logic             cnt_last;
	logic             ch_ok;
	logic [IDX_W-1:0] addr;
	logic [TW-1:0]    start_rd;
	logic [TW-1:0]    seen_t_rd;
	logic             seen_rd;
	logic [TW-1:0]    pulse_w;
	logic             in_band;
	logic [TW-1:0]    age;
	logic [TW:0]      cap33;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_pulse_q <= rcpwm_pkg::MIN_PULSE_RST;
			max_pulse_q <= rcpwm_pkg::MAX_PULSE_RST;
			timeout_q   <= rcpwm_pkg::LINK_TIMEOUT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rcpwm_pkg::REG_MIN_PULSE:    min_pulse_q <= cfg_data[PW-1:0];
				rcpwm_pkg::REG_MAX_PULSE:    max_pulse_q <= cfg_data[PW-1:0];
				rcpwm_pkg::REG_LINK_TIMEOUT: timeout_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Capture the accepted transaction.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q  <= kind;
			ch_q    <= channel;
			level_q <= edge_level;
			now_q   <= now_us;
		end
	end

	// Shared read address: the edge channel, or the counter during a poll.
	assign cnt_last = (cnt_q == IDX_W'(NUM_CHANNELS - 1));
	assign ch_ok    = ({1'b0, ch_q} < 4'(NUM_CHANNELS));
	assign addr     = cmd.edge_op ? ch_q[IDX_W-1:0] : cnt_q;

	assign start_rd  = start_q[addr];
	assign seen_t_rd = seen_t_q[addr];
	assign seen_rd   = seen_q[addr];

	// Edge arithmetic: pulse width and band check.
	assign pulse_w = now_q - start_rd;
	assign in_band = (pulse_w >= {{(TW-PW){1'b0}}, min_pulse_q}) &&
	                 (pulse_w <= {{(TW-PW){1'b0}}, max_pulse_q});

	// Channel age for the scan; an unseen channel is as stale as can be.
	assign age   = seen_rd ? (now_q - seen_t_rd) : rcpwm_pkg::NEVER_SEEN_AGE;
	assign cap33 = {1'b0, timeout_q} + 33'd1;

	// Per-channel state update on an edge.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				start_q[i]  <= '0;
				width_q[i]  <= rcpwm_pkg::WIDTH_RST;
				seen_t_q[i] <= '0;
				seen_q[i]   <= 1'b0;
			end
		end else if (cmd.edge_op && ch_ok) begin
			if (level_q) begin
				start_q[addr] <= now_q;
			end else if ((start_rd != '0) && in_band) begin
				width_q[addr]  <= pulse_w[PW-1:0];
				seen_t_q[addr] <= now_q;
				seen_q[addr]   <= 1'b1;
			end
		end
	end

	// Channel counter, shared by the scan and the result sequence.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load) begin
			cnt_q <= '0;
		end else if (cmd.scan || cmd.advance) begin
			cnt_q <= cnt_last ? '0 : cnt_q + IDX_W'(1);
		end
	end

	// Poll summary: freshness, worst age, cap and last-frame time.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			fresh_q <= 1'b1;
			worst_q <= '0;
		end else if (cmd.scan) begin
			if (!seen_rd || (age > timeout_q)) begin
				fresh_q <= 1'b0;
			end
			if (age > worst_q) begin
				worst_q <= age;
			end
		end else if (cmd.cap) begin
			if ({1'b0, worst_q} > cap33) begin
				worst_q <= cap33[TW-1:0];
			end
		end
		if (cmd.lf) begin
			lf_q <= now_q - worst_q;
		end
	end

	// Status and result fields.
	assign sts.kind     = kind_q;
	assign sts.cnt_last = cnt_last;

	assign out_channel   = rcpwm_pkg::CH_W'(cnt_q);
	assign chan_width    = width_q[addr];
	assign link_valid    = fresh_q;
	assign frame_time_us = lf_q;
	assign last          = cnt_last;

endmodule
`default_nettype wire

@@ rtl/core/rcpwm_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// RC PWM capture controller
// Sequences one transaction at a time: an edge update, or a poll made of a
// channel scan, the cap and last-frame steps, and one result per channel.
// ----------------------------------------------------------------------------
module rcpwm_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  wire logic            out_stall,
	input  wire logic            kind,
	input  wire rcpwm_pkg::sts_t sts,
	output rcpwm_pkg::cmd_t      cmd
);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_EDGE = 6'b000010,
		S_SCAN = 6'b000100,
		S_CAP  = 6'b001000,
		S_LF   = 6'b010000,
		S_EMIT = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_nxt;

	// Next state and commands.
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_stall  = 1'b1;
		out_valid = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = kind ? S_SCAN : S_EDGE;
				end
			end
			S_EDGE: begin
				cmd.edge_op = 1'b1;
				state_nxt   = S_IDLE;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.cnt_last) begin
					state_nxt = S_CAP;
				end
			end
			S_CAP: begin
				cmd.cap   = 1'b1;
				state_nxt = S_LF;
			end
			S_LF: begin
				cmd.lf    = 1'b1;
				state_nxt = S_EMIT;
			end
			S_EMIT: begin
				out_valid = 1'b1;
				if (!out_stall) begin
					cmd.advance = 1'b1;
					if (sts.cnt_last) begin
						state_nxt = S_IDLE;
					end
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/rc_pwm_capture_with_link_timeout_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// RC PWM capture with link timeout, top level
// Pulse-width capture on up to NUM_CHANNELS servo inputs with a poll that
// reports every channel's width and the link freshness.
// ----------------------------------------------------------------------------
// The block takes one transaction at a time. An edge transaction is
// accepted, then the channel state is updated. A poll transaction is
// accepted, then folds the channel ages one channel at a time through a
// single subtract and compare unit, then applies the cap and forms the
// last-frame time before its first result. It then shows NUM_CHANNELS
// results, channel 0 first, one per cycle when the output is not
// stalled, with last set on the final one. The input is stalled until
// the final result has been taken. Configuration writes are taken at
// any time but should only be made while the block is idle.
// ----------------------------------------------------------------------------
module rc_pwm_capture_with_link_timeout_top #(
	parameter int unsigned NUM_CHANNELS = rcpwm_pkg::NUM_CHANNELS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [rcpwm_pkg::IDX_REG_W-1:0] cfg_index,
	input  wire logic [rcpwm_pkg::TIME_W-1:0]    cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic                            kind,
	input  wire logic [rcpwm_pkg::CH_W-1:0]      channel,
	input  wire logic                            edge_level,
	input  wire logic [rcpwm_pkg::TIME_W-1:0]    now_us,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic [rcpwm_pkg::CH_W-1:0]           out_channel,
	output logic [rcpwm_pkg::PULSE_W-1:0]        chan_width,
	output logic                                 link_valid,
	output logic [rcpwm_pkg::TIME_W-1:0]         frame_time_us,
	output logic                                 last
);

	rcpwm_pkg::cmd_t cmd;
	rcpwm_pkg::sts_t sts;

	// Sequencer.
	rcpwm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.kind      (kind),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Capture state and arithmetic.
	rcpwm_dp #(
		.NUM_CHANNELS (NUM_CHANNELS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.kind          (kind),
		.channel       (channel),
		.edge_level    (edge_level),
		.now_us        (now_us),
		.cmd           (cmd),
		.sts           (sts),
		.out_channel   (out_channel),
		.chan_width    (chan_width),
		.link_valid    (link_valid),
		.frame_time_us (frame_time_us),
		.last          (last)
	);

endmodule
`default_nettype wire
